// ===== rtl/core/spiral_sphere_point_rotator_unit_macros.svh =====
// Assertion macros for the spiral sphere point rotator
`ifndef SPIRAL_SPHERE_POINT_ROTATOR_UNIT_MACROS_SVH
`define SPIRAL_SPHERE_POINT_ROTATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SSR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SSR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ssr_pkg.sv =====
// Shared types, constants and tables for the spiral sphere point rotator
`timescale 1ns / 1ps
package ssr_pkg;

    localparam int RADIUS_DEF = 16384;

    localparam logic [31:0] THETA_RATE_RST = 32'd16777216;
    localparam logic [31:0] PHI_RATE_RST   = 32'd8388608;
    localparam logic [23:0] START_TILT_RST = 24'd1398101;
    localparam logic [23:0] STEP_X_RST     = 24'd267;
    localparam logic [23:0] STEP_YZ_RST    = 24'd0;

    localparam logic [16:0] T_ONE = 17'h10000;

    // register indexes
    localparam logic [2:0] CFG_THETA_RATE = 3'd0;
    localparam logic [2:0] CFG_PHI_RATE   = 3'd1;
    localparam logic [2:0] CFG_START_X    = 3'd2;
    localparam logic [2:0] CFG_START_Y    = 3'd3;
    localparam logic [2:0] CFG_START_Z    = 3'd4;
    localparam logic [2:0] CFG_STEP_X     = 3'd5;
    localparam logic [2:0] CFG_STEP_Y     = 3'd6;
    localparam logic [2:0] CFG_STEP_Z     = 3'd7;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [3:0] CORDIC_LAST = 4'd15;
    localparam logic [2:0] ANG_LAST    = 3'd4;
    localparam logic [4:0] MAC_LAST    = 5'd16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ANG,
        S_CORD,
        S_MAC,
        S_DONE
    } t_state;

    // destinations of the multiply-accumulate sequence
    typedef enum logic [3:0] {
        D_TMP,
        D_X,
        D_Y,
        D_Z,
        D_YX,
        D_ZX,
        D_XY,
        D_ZY,
        D_XZ,
        D_YZ
    } t_dst;

    typedef struct packed {
        logic               done;
        logic signed [15:0] cos_v;
        logic signed [15:0] sin_v;
    } t_cordic_res;

    // arctangent of 2^-i in 24-bit turns
    function automatic logic signed [24:0] atan_turns(input logic [3:0] idx);
        logic signed [24:0] v;
        case (idx)
            4'd0:    v = 25'sd2097152;
            4'd1:    v = 25'sd1238021;
            4'd2:    v = 25'sd654136;
            4'd3:    v = 25'sd332050;
            4'd4:    v = 25'sd166669;
            4'd5:    v = 25'sd83414;
            4'd6:    v = 25'sd41718;
            4'd7:    v = 25'sd20860;
            4'd8:    v = 25'sd10430;
            4'd9:    v = 25'sd5215;
            4'd10:   v = 25'sd2608;
            4'd11:   v = 25'sd1304;
            4'd12:   v = 25'sd652;
            4'd13:   v = 25'sd326;
            4'd14:   v = 25'sd163;
            default: v = 25'sd81;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/ssr_cordic.sv =====
// Iterative rotation CORDIC giving cos and sin of a 24-bit-turn angle in Q1.14
`timescale 1ns / 1ps
module ssr_cordic
    import ssr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_angle,
    output t_cordic_res o_res
);

    logic               r_busy;
    logic               r_fin;
    logic               r_done;
    logic [3:0]         r_i;
    logic               r_neg;
    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [24:0] r_z;
    logic signed [15:0] r_cos;
    logic signed [15:0] r_sin;

    logic [23:0]        w_flip;
    logic               w_fold;
    logic signed [33:0] w_xs;
    logic signed [33:0] w_ys;
    logic signed [24:0] w_at;
    logic signed [17:0] w_xr;
    logic signed [17:0] w_yr;
    logic signed [15:0] w_xc;
    logic signed [15:0] w_yc;

    // fold the angle into a quarter turn either side of zero
    assign w_flip = i_angle + 24'h800000;
    assign w_fold = ($signed(i_angle) > 24'sd4194304) || ($signed(i_angle) < -24'sd4194304);

    // shared shift and add step
    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;
    assign w_at = atan_turns(r_i);

    // round to Q1.14 and clamp to plus or minus one
    assign w_xr = 18'((r_x + 34'sd32768) >>> 16);
    assign w_yr = 18'((r_y + 34'sd32768) >>> 16);
    assign w_xc = (w_xr > 18'sd16384) ? 16'sd16384 :
                  (w_xr < -18'sd16384) ? -16'sd16384 : w_xr[15:0];
    assign w_yc = (w_yr > 18'sd16384) ? 16'sd16384 :
                  (w_yr < -18'sd16384) ? -16'sd16384 : w_yr[15:0];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 4'd1;
                if (r_i == CORDIC_LAST) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_x   <= CORDIC_GAIN;
            r_y   <= '0;
            r_neg <= w_fold;
            r_z   <= w_fold ? 25'($signed(w_flip)) : 25'($signed(i_angle));
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end
        end
        if (r_fin) begin
            r_cos <= r_neg ? -w_xc : w_xc;
            r_sin <= r_neg ? -w_yc : w_yc;
        end
    end

    assign o_res.done  = r_done;
    assign o_res.cos_v = r_cos;
    assign o_res.sin_v = r_sin;

endmodule

// ===== rtl/core/spiral_sphere_point_rotator_unit.sv =====
// Top level: spiral sphere point generator with X, Y, Z tilt rotation
// Each request takes two phase products, 5 CORDIC runs and 17 multiply-accumulate
// steps on one multiplier; a new request is not taken until the current one finishes.
// Reset: synchronous active low; registers take their defaults, tilts the start values.
// The input is stalled from accept until the result moves into the output register.
`timescale 1ns / 1ps
`include "spiral_sphere_point_rotator_unit_macros.svh"
module spiral_sphere_point_rotator_unit
    import ssr_pkg::*;
#(
    parameter int RADIUS = RADIUS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [16:0]        i_t_phase,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_x_out,
    output logic signed [15:0] o_y_out,
    output logic signed [15:0] o_z_out,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);

    t_state r_state;
    t_state n_state;

    logic [31:0] r_theta_rate;
    logic [31:0] r_phi_rate;
    logic [23:0] r_step_x;
    logic [23:0] r_step_y;
    logic [23:0] r_step_z;
    logic [23:0] r_ang_x;
    logic [23:0] r_ang_y;
    logic [23:0] r_ang_z;

    logic [16:0] r_t;
    logic [23:0] r_theta;
    logic [23:0] r_phi;
    logic [4:0]  r_op;
    logic        r_ph;
    logic [2:0]  r_cidx;
    logic        r_cwait;

    logic signed [15:0] r_cs [5];
    logic signed [15:0] r_sn [5];

    logic signed [50:0] r_prod;
    logic signed [51:0] r_acc;
    logic signed [17:0] r_tmp, r_x, r_y, r_z, r_yx, r_zx, r_xy, r_zy, r_xz, r_yz;

    logic               r_out_valid;
    logic signed [15:0] r_xo, r_yo, r_zo;

    logic               w_cstart;
    logic               w_load;
    logic [23:0]        w_cangle;
    t_cordic_res        w_cres;

    logic signed [32:0] w_ma;
    logic signed [17:0] w_mb;
    logic               w_acc;
    logic               w_sub;
    logic               w_wr;
    t_dst               w_dst;
    logic signed [51:0] w_sum;
    logic signed [17:0] w_rnd;
    logic signed [17:0] w_rad;

    assign w_rad = 18'(RADIUS);

    // shared CORDIC
    ssr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cstart),
        .i_angle (w_cangle),
        .o_res   (w_cres)
    );

    always_comb begin
        case (r_cidx)
            3'd0:    w_cangle = r_theta;
            3'd1:    w_cangle = r_phi;
            3'd2:    w_cangle = r_ang_x;
            3'd3:    w_cangle = r_ang_y;
            default: w_cangle = r_ang_z;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_ANG;
            S_ANG:  if (r_ph && r_op[0]) n_state = S_CORD;
            S_CORD: if (w_cres.done && r_cidx == ANG_LAST) n_state = S_MAC;
            S_MAC:  if (r_ph && r_op == MAC_LAST) n_state = S_DONE;
            S_DONE: if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        w_cstart   = (r_state == S_CORD) && !r_cwait;
        w_load     = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    end

    // multiplier operand selection
    always_comb begin
        w_ma  = '0;
        w_mb  = '0;
        w_acc = 1'b0;
        w_sub = 1'b0;
        w_wr  = 1'b0;
        w_dst = D_TMP;
        if (r_state == S_ANG) begin
            w_ma = {1'b0, (r_op[0] ? r_phi_rate : r_theta_rate)};
            w_mb = {1'b0, r_t};
        end else begin
            case (r_op)
                5'd0:  begin w_ma = 33'(r_cs[0]); w_mb = 18'(r_sn[1]); w_wr = 1'b1; w_dst = D_TMP; end
                5'd1:  begin w_ma = 33'(r_tmp); w_mb = w_rad; w_wr = 1'b1; w_dst = D_X; end
                5'd2:  begin w_ma = 33'(r_sn[0]); w_mb = 18'(r_sn[1]); w_wr = 1'b1; w_dst = D_TMP; end
                5'd3:  begin w_ma = 33'(r_tmp); w_mb = w_rad; w_wr = 1'b1; w_dst = D_Y; end
                5'd4:  begin w_ma = 33'(r_cs[1]); w_mb = w_rad; w_wr = 1'b1; w_dst = D_Z; end
                5'd5:  begin w_ma = 33'(r_y); w_mb = 18'(r_cs[2]); end
                5'd6:  begin
                    w_ma = 33'(r_z); w_mb = 18'(r_sn[2]);
                    w_acc = 1'b1; w_sub = 1'b1; w_wr = 1'b1; w_dst = D_YX;
                end
                5'd7:  begin w_ma = 33'(r_y); w_mb = 18'(r_sn[2]); end
                5'd8:  begin
                    w_ma = 33'(r_z); w_mb = 18'(r_cs[2]);
                    w_acc = 1'b1; w_wr = 1'b1; w_dst = D_ZX;
                end
                5'd9:  begin w_ma = 33'(r_x); w_mb = 18'(r_cs[3]); end
                5'd10: begin
                    w_ma = 33'(r_zx); w_mb = 18'(r_sn[3]);
                    w_acc = 1'b1; w_wr = 1'b1; w_dst = D_XY;
                end
                5'd11: begin w_ma = 33'(r_zx); w_mb = 18'(r_cs[3]); end
                5'd12: begin
                    w_ma = 33'(r_x); w_mb = 18'(r_sn[3]);
                    w_acc = 1'b1; w_sub = 1'b1; w_wr = 1'b1; w_dst = D_ZY;
                end
                5'd13: begin w_ma = 33'(r_xy); w_mb = 18'(r_cs[4]); end
                5'd14: begin
                    w_ma = 33'(r_yx); w_mb = 18'(r_sn[4]);
                    w_acc = 1'b1; w_sub = 1'b1; w_wr = 1'b1; w_dst = D_XZ;
                end
                5'd15: begin w_ma = 33'(r_xy); w_mb = 18'(r_sn[4]); end
                default: begin
                    w_ma = 33'(r_yx); w_mb = 18'(r_cs[4]);
                    w_acc = 1'b1; w_wr = 1'b1; w_dst = D_YZ;
                end
            endcase
        end
    end

    // accumulate and round to Q1.14
    assign w_sum = (w_acc ? r_acc : 52'sd0) + (w_sub ? -52'(r_prod) : 52'(r_prod));
    assign w_rnd = 18'((w_sum + 52'sd8192) >>> 14);

    // state and sequencing counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= '0;
            r_ph    <= 1'b0;
            r_cidx  <= '0;
            r_cwait <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_ANG || r_state == S_MAC) begin
                r_ph <= !r_ph;
                if (r_ph) r_op <= (n_state == r_state) ? r_op + 5'd1 : 5'd0;
            end else begin
                r_ph <= 1'b0;
                r_op <= '0;
            end
            if (w_cstart) r_cwait <= 1'b1;
            if (w_cres.done) begin
                r_cwait <= 1'b0;
                r_cidx  <= (r_cidx == ANG_LAST) ? 3'd0 : r_cidx + 3'd1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) r_t <= i_t_phase;
        if (!r_ph) r_prod <= 51'(w_ma) * 51'(w_mb);
        if (r_state == S_ANG && r_ph) begin
            if (r_op[0]) r_phi   <= r_prod[39:16];
            else         r_theta <= r_prod[39:16];
        end
        if (w_cres.done) begin
            r_cs[r_cidx] <= w_cres.cos_v;
            r_sn[r_cidx] <= w_cres.sin_v;
        end
        if (r_state == S_MAC && r_ph) begin
            r_acc <= w_sum;
            if (w_wr) begin
                case (w_dst)
                    D_TMP:   r_tmp <= w_rnd;
                    D_X:     r_x   <= w_rnd;
                    D_Y:     r_y   <= w_rnd;
                    D_Z:     r_z   <= w_rnd;
                    D_YX:    r_yx  <= w_rnd;
                    D_ZX:    r_zx  <= w_rnd;
                    D_XY:    r_xy  <= w_rnd;
                    D_ZY:    r_zy  <= w_rnd;
                    D_XZ:    r_xz  <= w_rnd;
                    default: r_yz  <= w_rnd;
                endcase
            end
        end
        if (w_load) begin
            r_xo <= r_xz[15:0];
            r_yo <= r_yz[15:0];
            r_zo <= r_zy[15:0];
        end
    end

    // configuration registers, tilts and output valid
    // start tilt writes are ignored; reset restores the defaults
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_theta_rate <= THETA_RATE_RST;
            r_phi_rate   <= PHI_RATE_RST;
            r_step_x     <= STEP_X_RST;
            r_step_y     <= STEP_YZ_RST;
            r_step_z     <= STEP_YZ_RST;
            r_ang_x      <= START_TILT_RST;
            r_ang_y      <= START_TILT_RST;
            r_ang_z      <= START_TILT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_THETA_RATE: r_theta_rate <= i_cfg_data;
                    CFG_PHI_RATE:   r_phi_rate   <= i_cfg_data;
                    CFG_STEP_X:     r_step_x     <= i_cfg_data[23:0];
                    CFG_STEP_Y:     r_step_y     <= i_cfg_data[23:0];
                    CFG_STEP_Z:     r_step_z     <= i_cfg_data[23:0];
                    default:        ;
                endcase
            end
            if (w_load && r_t == T_ONE) begin
                r_ang_x <= r_ang_x + r_step_x;
                r_ang_y <= r_ang_y + r_step_y;
                r_ang_z <= r_ang_z + r_step_z;
            end
            if (w_load)                         r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_x_out     = r_xo;
    assign o_y_out     = r_yo;
    assign o_z_out     = r_zo;

    `SSR_ASSERT_IMP(a_cordic_done_in_cord, w_cres.done, r_state == S_CORD, "CORDIC result outside its phase")
    `SSR_ASSERT_NXT(a_tilt_hold, !w_load, $stable(r_ang_x) && $stable(r_ang_y), "tilt moved without a result")
    `SSR_ASSERT_IMP(a_cidx_range, 1'b1, r_cidx <= ANG_LAST, "angle index out of range")

endmodule
